// ----- sv/bts_pkg.sv -----
package bts_pkg;

    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] block_count;
        logic [7:0]  payload_byte;
        logic [7:0]  rx_byte;
    } t_in;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic [2:0]  status;
        logic        payload_ready;
        logic [7:0]  nak_count;
        logic [7:0]  block_number;
    } t_out;

    localparam logic [2:0] OP_START = 3'd0;
    localparam logic [2:0] OP_PAYLOAD = 3'd1;
    localparam logic [2:0] OP_RX = 3'd2;
    localparam logic [2:0] OP_TICK = 3'd3;
    localparam logic [2:0] OP_SLOT = 3'd4;

    localparam logic [1:0] REG_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_SYNC = 2'd1;
    localparam logic [1:0] REG_BLOCK = 2'd2;
    localparam logic [1:0] REG_SETTLE = 2'd3;

    localparam logic [7:0] BYTE_START = 8'h01;
    localparam logic [7:0] BYTE_END = 8'h04;
    localparam logic [7:0] BYTE_ACK = 8'h06;
    localparam logic [7:0] BYTE_NAK = 8'h15;
    localparam logic [7:0] BYTE_CAN = 8'h18;
    localparam logic [7:0] BYTE_ESC = 8'h1b;
    localparam logic [7:0] BYTE_ABORT = 8'h61;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_BUSY = 3'd1;
    localparam logic [2:0] ST_DONE = 3'd2;
    localparam logic [2:0] ST_NOSYNC = 3'd3;
    localparam logic [2:0] ST_HDRFAIL = 3'd4;
    localparam logic [2:0] ST_DATAFAIL = 3'd5;

    typedef enum logic [14:0] {
        PH_IDLE      = 15'h0001,
        PH_SEND_ESC  = 15'h0002,
        PH_SETTLE    = 15'h0004,
        PH_SEND_ABRT = 15'h0008,
        PH_WAIT_CAN  = 15'h0010,
        PH_FILL      = 15'h0020,
        PH_SEND_FRM  = 15'h0040,
        PH_WAIT_ACK  = 15'h0080,
        PH_SEND_CAN  = 15'h0100,
        PH_SEND_EOT  = 15'h0200,
        PH_WAIT_EOT  = 15'h0400,
        PH_DONE      = 15'h0800,
        PH_NOSYNC    = 15'h1000,
        PH_HDRFAIL   = 15'h2000,
        PH_DATAFAIL  = 15'h4000
    } t_phase;

    // Frame byte source selected by the engine, resolved in the back end.
    typedef enum logic [2:0] {
        SRC_NONE = 3'd0,
        SRC_CONST = 3'd1,
        SRC_STORE = 3'd2
    } t_src;

    typedef struct packed {
        t_src        src;
        logic [7:0]  tx_byte;
        logic [2:0]  status;
        logic        payload_ready;
        logic [7:0]  nak_count;
        logic [7:0]  block_number;
    } t_job;

endpackage

// ----- sv/bts_ram.sv -----
module bts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- sv/bts_engine.sv -----
// Front part: protocol sequencer, one input beat per cycle while i_fire is high.
module bts_engine #(
    parameter int BLOCK_BYTES = 128
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_index,
    input  logic [7:0]                     i_cfg_data,
    input  logic                           i_fire,
    input  bts_pkg::t_in                   i_item,
    output logic                           o_we,
    output logic [$clog2(BLOCK_BYTES)-1:0] o_waddr,
    output logic [7:0]                     o_wdata,
    output logic [$clog2(BLOCK_BYTES)-1:0] o_raddr,
    output bts_pkg::t_job                  o_job
);
    import bts_pkg::*;

    localparam int AW = $clog2(BLOCK_BYTES);
    localparam int IW = $clog2(BLOCK_BYTES + 5);
    localparam logic [IW:0] FRAME_LEN = (IW+1)'(BLOCK_BYTES + 5);
    localparam logic [IW:0] CK_LO = (IW+1)'(BLOCK_BYTES + 3);
    localparam logic [AW:0] FULL = (AW+1)'(BLOCK_BYTES);

    logic [7:0] r_timeout, r_sync, r_blkr, r_settle;
    t_phase r_phase, n_phase;
    logic [AW:0] r_fill, n_fill;
    logic [IW:0] r_sidx, n_sidx;
    logic [15:0] r_sum, n_sum, r_frame, n_frame, r_total, n_total;
    logic [3:0] r_tries, n_tries;
    logic [7:0] r_wait, n_wait, r_fail, n_fail;
    logic [7:0] wait_dec;
    logic [3:0] blk_min, sync_min, tries_dec;
    logic [IW:0] sidx_inc;
    logic [7:0] num;
    t_src src;
    logic [7:0] cbyte;
    logic [2:0] st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= 8'd50;
            r_sync <= 8'd3;
            r_blkr <= 8'd10;
            r_settle <= 8'd15;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_TIMEOUT: r_timeout <= i_cfg_data;
                REG_SYNC:    r_sync <= {4'd0, i_cfg_data[3:0]};
                REG_BLOCK:   r_blkr <= {4'd0, i_cfg_data[3:0]};
                REG_SETTLE:  r_settle <= i_cfg_data;
                default:     r_settle <= r_settle;
            endcase
        end
    end

    assign wait_dec = (r_wait != 8'd0) ? r_wait - 8'd1 : 8'd0;
    assign tries_dec = (r_tries != 4'd0) ? r_tries - 4'd1 : 4'd0;
    assign blk_min = (r_blkr[3:0] != 4'd0) ? r_blkr[3:0] : 4'd1;
    assign sync_min = (r_sync[3:0] != 4'd0) ? r_sync[3:0] : 4'd1;
    assign sidx_inc = r_sidx + 1'b1;
    assign num = r_frame[7:0];

    always_comb begin
        n_phase = r_phase; n_fill = r_fill; n_sidx = r_sidx; n_sum = r_sum;
        n_frame = r_frame; n_total = r_total; n_tries = r_tries;
        n_wait = r_wait; n_fail = r_fail;
        src = SRC_NONE; cbyte = 8'd0;
        o_we = 1'b0;
        o_waddr = r_fill[AW-1:0];
        o_wdata = i_item.payload_byte;
        o_raddr = AW'(r_sidx - (IW+1)'(3));
        if (i_fire) begin
            case (i_item.operation)
                OP_START: begin
                    n_total = i_item.block_count; n_frame = '0; n_sidx = '0;
                    n_fill = '0; n_sum = '0; n_tries = '0; n_wait = '0;
                    n_phase = PH_SEND_ESC;
                end
                OP_PAYLOAD: begin
                    if (r_phase == PH_FILL && r_fill < FULL) begin
                        o_we = 1'b1;
                        n_sum = r_sum + {8'd0, i_item.payload_byte};
                        n_fill = r_fill + 1'b1;
                        if (n_fill >= FULL) begin
                            n_sidx = '0; n_tries = blk_min; n_phase = PH_SEND_FRM;
                        end
                    end
                end
                OP_RX, OP_TICK: begin
                    logic ack, fail, exp;
                    ack = 1'b0; fail = 1'b0;
                    exp = (i_item.operation == OP_TICK) && (wait_dec == 8'd0);
                    if (i_item.operation == OP_TICK) begin
                        if (r_phase == PH_SETTLE || r_phase == PH_WAIT_CAN ||
                            r_phase == PH_WAIT_ACK || r_phase == PH_WAIT_EOT) begin
                            n_wait = wait_dec;
                        end
                    end
                    case (r_phase)
                        PH_SETTLE: if (exp) n_phase = PH_SEND_ABRT;
                        PH_WAIT_CAN: begin
                            if (i_item.operation == OP_RX) begin
                                if (i_item.rx_byte == BYTE_CAN) begin
                                    n_fill = '0; n_sum = '0; n_phase = PH_FILL;
                                end
                            end else if (exp) begin
                                n_tries = tries_dec;
                                n_phase = (tries_dec != 4'd0) ? PH_SEND_ABRT : PH_NOSYNC;
                            end
                        end
                        PH_WAIT_ACK: begin
                            if (i_item.operation == OP_RX) begin
                                ack = (i_item.rx_byte == BYTE_ACK);
                                fail = (i_item.rx_byte == BYTE_NAK);
                            end else begin
                                fail = exp;
                            end
                        end
                        PH_WAIT_EOT: begin
                            if (i_item.operation == OP_RX) begin
                                if (i_item.rx_byte == BYTE_ACK || i_item.rx_byte == BYTE_NAK)
                                    n_phase = PH_DONE;
                            end else if (exp) begin
                                n_phase = PH_DONE;
                            end
                        end
                        default: n_phase = r_phase;
                    endcase
                    if (ack) begin
                        if (r_frame == r_total) n_phase = PH_SEND_EOT;
                        else begin
                            n_frame = r_frame + 16'd1;
                            n_fill = '0; n_sum = '0; n_phase = PH_FILL;
                        end
                    end
                    if (fail) begin
                        n_fail = r_fail + 8'd1;
                        n_tries = tries_dec;
                        if (tries_dec != 4'd0) begin
                            n_sidx = '0; n_phase = PH_SEND_FRM;
                        end else if (r_frame == 16'd0) begin
                            n_phase = PH_HDRFAIL;
                        end else begin
                            n_sidx = '0; n_phase = PH_SEND_CAN;
                        end
                    end
                end
                OP_SLOT: begin
                    case (r_phase)
                        PH_SEND_ESC: begin
                            src = SRC_CONST; cbyte = BYTE_ESC; n_sidx = sidx_inc;
                            if (sidx_inc >= (IW+1)'(2)) begin
                                n_sidx = '0; n_tries = sync_min;
                                if (r_settle != 8'd0) begin
                                    n_wait = r_settle; n_phase = PH_SETTLE;
                                end else n_phase = PH_SEND_ABRT;
                            end
                        end
                        PH_SEND_ABRT: begin
                            src = SRC_CONST; cbyte = BYTE_ABORT;
                            n_wait = r_timeout; n_phase = PH_WAIT_CAN;
                        end
                        PH_SEND_FRM: begin
                            src = SRC_CONST;
                            if (r_sidx == '0) cbyte = BYTE_START;
                            else if (r_sidx == (IW+1)'(1)) cbyte = num;
                            else if (r_sidx == (IW+1)'(2)) cbyte = ~num;
                            else if (r_sidx < CK_LO) src = SRC_STORE;
                            else if (r_sidx == CK_LO) cbyte = r_sum[7:0];
                            else cbyte = r_sum[15:8];
                            n_sidx = sidx_inc;
                            if (sidx_inc >= FRAME_LEN) begin
                                n_sidx = '0; n_wait = r_timeout; n_phase = PH_WAIT_ACK;
                            end
                        end
                        PH_SEND_CAN: begin
                            src = SRC_CONST; cbyte = BYTE_CAN; n_sidx = sidx_inc;
                            if (sidx_inc >= (IW+1)'(2)) begin
                                n_sidx = '0; n_phase = PH_DATAFAIL;
                            end
                        end
                        PH_SEND_EOT: begin
                            src = SRC_CONST; cbyte = BYTE_END;
                            n_wait = r_timeout; n_phase = PH_WAIT_EOT;
                        end
                        default: src = SRC_NONE;
                    endcase
                end
                default: n_phase = r_phase;
            endcase
        end
        case (n_phase)
            PH_IDLE:     st = ST_IDLE;
            PH_DONE:     st = ST_DONE;
            PH_NOSYNC:   st = ST_NOSYNC;
            PH_HDRFAIL:  st = ST_HDRFAIL;
            PH_DATAFAIL: st = ST_DATAFAIL;
            default:     st = ST_BUSY;
        endcase
        o_job.src = src;
        o_job.tx_byte = cbyte;
        o_job.status = st;
        o_job.payload_ready = (n_phase == PH_FILL);
        o_job.nak_count = n_fail;
        o_job.block_number = n_frame[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_fill <= '0; r_sidx <= '0; r_sum <= '0;
            r_frame <= '0; r_total <= '0; r_tries <= '0; r_wait <= '0; r_fail <= '0;
        end else begin
            r_phase <= n_phase; r_fill <= n_fill; r_sidx <= n_sidx; r_sum <= n_sum;
            r_frame <= n_frame; r_total <= n_total; r_tries <= n_tries;
            r_wait <= n_wait; r_fail <= n_fail;
        end
    end
endmodule

// ----- sv/bts_backend.sv -----
// Back part: two-entry queue of jobs; frame-store read data joins the entry its job went to.
module bts_backend (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bts_pkg::t_job i_job,
    input  logic [7:0]    i_rdata,
    output logic          o_full,
    output logic          o_valid,
    input  logic          i_stall,
    output bts_pkg::t_out o_item
);
    import bts_pkg::*;

    // Slot 0 is head. Store reads land in the cycle after push, patched into the entry.
    t_job r_q [2];
    logic [7:0] r_b [2];
    logic [1:0] r_cnt, n_cnt;
    logic r_pend;
    logic [0:0] r_pslot;
    logic pop;
    logic [7:0] head_byte;

    assign pop = (r_cnt != 2'd0) && !i_stall && !(r_pend && r_pslot == 1'b0);
    assign o_valid = (r_cnt != 2'd0) && !(r_pend && r_pslot == 1'b0);
    assign o_full = (r_cnt == 2'd2) && !pop;
    assign n_cnt = r_cnt + {1'b0, i_push} - {1'b0, pop};
    assign head_byte = (r_q[0].src == SRC_STORE) ? r_b[0] : r_q[0].tx_byte;

    always_comb begin
        o_item.tx_valid = (r_q[0].src != SRC_NONE);
        o_item.tx_byte = head_byte;
        o_item.status = r_q[0].status;
        o_item.payload_ready = r_q[0].payload_ready;
        o_item.nak_count = r_q[0].nak_count;
        o_item.block_number = r_q[0].block_number;
    end

    always_ff @(posedge i_clk) begin
        logic [7:0] b0, b1;
        logic [0:0] wslot;
        b0 = r_b[0]; b1 = r_b[1];
        if (r_pend) begin
            if (r_pslot == 1'b0) b0 = i_rdata; else b1 = i_rdata;
        end
        if (pop) begin
            r_q[0] <= r_q[1]; b0 = b1;
        end
        wslot = (r_cnt - {1'b0, pop}) == 2'd0 ? 1'b0 : 1'b1;
        if (i_push) begin
            if (wslot == 1'b0) r_q[0] <= i_job; else r_q[1] <= i_job;
        end
        r_b[0] <= b0; r_b[1] <= b1;
        if (!i_rst_n) begin
            r_cnt <= '0; r_pend <= 1'b0; r_pslot <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_pend <= i_push && (i_job.src == SRC_STORE);
            r_pslot <= wslot;
        end
    end
endmodule

// ----- sv/block_transfer_sender.sv -----
// Results: a beat's result enters the result queue on acceptance; one that carries
//   a frame-store payload byte is offered only once the registered store read lands.
// Throughput: one input beat per cycle while o_stall is low; the two-entry result queue absorbs stalls.
// Reset: synchronous active-low i_rst_n returns the sequencer to idle, zeroes all
//   counters and restores register defaults; the frame store is not cleared.
module block_transfer_sender #(
    parameter int BLOCK_BYTES = 128
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [7:0]       i_cfg_data,
    input  logic             i_valid,
    output logic             o_stall,
    input  bts_pkg::t_in     i_item,
    output logic             o_valid,
    input  logic             i_stall,
    output bts_pkg::t_out    o_item
);
    import bts_pkg::*;

    localparam int AW = $clog2(BLOCK_BYTES);

    logic fire, we, full;
    logic [AW-1:0] waddr, raddr;
    logic [7:0] wdata, rdata;
    t_job job;

    // Front end halts only when the result queue cannot take another beat.
    assign o_stall = full;
    assign fire = i_valid && !full;

    bts_engine #(.BLOCK_BYTES(BLOCK_BYTES)) u_engine (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_fire(fire), .i_item,
        .o_we(we), .o_waddr(waddr), .o_wdata(wdata), .o_raddr(raddr), .o_job(job)
    );

    // Frame payload store: written while filling, read while sending.
    bts_ram #(.WIDTH(8), .DEPTH(BLOCK_BYTES)) u_store (
        .i_clk, .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_re(fire && job.src == SRC_STORE), .i_raddr(raddr), .o_rdata(rdata)
    );

    bts_backend u_back (
        .i_clk, .i_rst_n, .i_push(fire), .i_job(job), .i_rdata(rdata),
        .o_full(full), .o_valid, .i_stall, .o_item
    );

    a_txb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_item.tx_valid |-> o_item.tx_byte == 8'd0)
        else $error("idle slot with nonzero byte");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.payload_ready |-> o_item.status == ST_BUSY)
        else $error("payload ready outside busy");
    a_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> fire && i_item.operation == OP_PAYLOAD)
        else $error("store write without payload beat");
endmodule
